// ----- design/pht_pkg.sv -----
`timescale 1ns / 1ps
// pht_pkg: request codes, result codes, field widths and the slot entry type
// shared by the process handle table and its port checker. No dependencies.
package pht_pkg;

  localparam int unsigned IdW       = 32;
  localparam int unsigned ActW      = 2;
  localparam int unsigned CodeW     = 2;
  localparam int unsigned OutSlotW  = 10;
  localparam int unsigned InTdataW  = 72;  // 65 bits used
  localparam int unsigned InTuserW  = 2;
  localparam int unsigned OutTdataW = 80;  // 76 bits used

  typedef enum logic [ActW-1:0] {
    ActAlloc   = 2'd0,
    ActLookup  = 2'd1,
    ActFree    = 2'd2,
    ActCurrent = 2'd3
  } action_e;

  typedef enum logic [CodeW-1:0] {
    ResOk     = 2'd0,
    ResNoFree = 2'd1,
    ResBadId  = 2'd2
  } result_e;

  typedef enum logic [2:0] {
    StClear = 3'b001,
    StIdle  = 3'b010,
    StExec  = 3'b100
  } state_e;

  typedef struct packed {
    logic           busy;
    logic [IdW-1:0] ident;
    logic [IdW-1:0] parent;
  } slot_entry_t;

endpackage

// ----- design/process_handle_table_top.sv -----
`timescale 1ns / 1ps
// process_handle_table_top: process slot table with a LIFO free stack and
// generational ids, held in a slot memory and a stack memory. Uses pht_pkg.
//
//  channel  | direction | payload
//  s_axis   | in        | tuser: action; tdata: target_id, parent_ident, check_perm
//  m_axis   | out       | tdata: result_code, slot_index, proc_id, proc_parent
//
// Each request has two steps: accept and memory read, then resolve and write back.
// The next request is taken right after; a result may wait in the output register.
// A stalled output holds the second step (memory read data stays registered).
// After reset a clearing pass over all SLOTS entries empties the table and refills
// the stack; no request is taken during it.
module process_handle_table_top #(
  parameter int unsigned SLOTS     = 1024,
  parameter int unsigned SLOT_BITS = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [31:0] target_id, [63:32] parent_ident, [64] check_perm, [71:65] zero
  input  logic [pht_pkg::InTdataW-1:0]   s_axis_tdata,
  // [1:0] action
  input  logic [pht_pkg::InTuserW-1:0]   s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [1:0] result_code, [11:2] slot_index, [43:12] proc_id, [75:44] proc_parent,
  // [79:76] zero
  output logic [pht_pkg::OutTdataW-1:0]  m_axis_tdata
);

  localparam int unsigned SB   = SLOT_BITS;
  localparam int unsigned CntW = $clog2(SLOTS + 1);
  localparam int unsigned CtrW = pht_pkg::IdW - 1 - SLOT_BITS;
  localparam int unsigned IdW  = pht_pkg::IdW;
  localparam logic [SB-1:0]   LastSlot = SB'(SLOTS - 1);
  localparam logic [SB:0]     SlotsExt = (SB + 1)'(SLOTS);
  localparam logic [CntW-1:0] SlotsCnt = CntW'(SLOTS);

  pht_pkg::slot_entry_t slot_mem [SLOTS];
  logic [SB-1:0]        stk_mem  [SLOTS];

  pht_pkg::state_e      state_q, state_d;
  logic [SB-1:0]        clr_q, clr_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [CtrW-1:0]      ctr_q, ctr_d;
  logic [IdW-1:0]       cur_q, cur_d;

  pht_pkg::action_e     act_q;
  logic [IdW-1:0]       tgt_q, par_q;
  logic                 perm_q;
  logic [SB-1:0]        rslot_q;

  pht_pkg::slot_entry_t ent_q;
  logic [SB-1:0]        stk_q;

  logic                 m_valid_q, m_valid_d;
  logic [pht_pkg::OutTdataW-1:0] m_data_q, m_data_d;

  logic                 accept, fire, out_free;
  logic [IdW-1:0]       in_tgt;
  logic [SB-1:0]        rd_slot, stk_raddr;
  logic [CntW-1:0]      cnt_m1;

  logic                 slot_we, stk_we;
  logic [SB-1:0]        slot_wa, stk_wa, stk_wd;
  pht_pkg::slot_entry_t slot_wd;

  logic                 cur_none, tgt_zero, zero_none, oob, bad, found;
  logic [CtrW-1:0]      ctr_inc, ctr_nx;
  logic [IdW-1:0]       new_id;
  pht_pkg::result_e     code;
  logic [SB-1:0]        res_slot;
  logic [IdW-1:0]       res_id, res_par, slot_ext;

  assign s_axis_tready = (state_q == pht_pkg::StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign fire          = (state_q == pht_pkg::StExec) && out_free;

  assign in_tgt    = s_axis_tdata[IdW-1:0];
  assign rd_slot   = (in_tgt == '0) ? cur_q[SB-1:0] : in_tgt[SB-1:0];
  assign cnt_m1    = cnt_q - 1'b1;
  assign stk_raddr = cnt_m1[SB-1:0];

  // resolve, allocate, free and set current; clearing-pass writes
  always_comb begin
    cur_none  = (cur_q == '0);
    tgt_zero  = (tgt_q == '0);
    zero_none = tgt_zero && cur_none;
    oob       = ({1'b0, tgt_q[SB-1:0]} >= SlotsExt);
    bad       = !tgt_zero && (oob || !ent_q.busy || (ent_q.ident != tgt_q) ||
                (perm_q && (cur_none ||
                 ((ent_q.ident != cur_q) && (ent_q.parent != cur_q)))));
    found     = !bad && !zero_none;
    ctr_inc   = ctr_q + 1'b1;
    ctr_nx    = (ctr_inc == '0) ? CtrW'(1) : ctr_inc;
    new_id    = {ctr_nx, 1'b0, stk_q};

    code     = pht_pkg::ResOk;
    res_slot = '0;
    res_id   = '0;
    res_par  = '0;
    ctr_d    = ctr_q;
    cnt_d    = cnt_q;
    cur_d    = cur_q;
    slot_we  = 1'b0;
    slot_wa  = rslot_q;
    slot_wd  = '{busy: 1'b0, ident: ent_q.ident, parent: ent_q.parent};
    stk_we   = 1'b0;
    stk_wa   = cnt_q[SB-1:0];
    stk_wd   = rslot_q;

    if (act_q == pht_pkg::ActAlloc) begin
      if (cnt_q == '0) begin
        code = pht_pkg::ResNoFree;
      end else begin
        res_slot = stk_q;
        res_id   = new_id;
        res_par  = par_q;
        if (fire) begin
          ctr_d   = ctr_nx;
          cnt_d   = cnt_m1;
          slot_we = 1'b1;
          slot_wa = stk_q;
          slot_wd = '{busy: 1'b1, ident: new_id, parent: par_q};
        end
      end
    end else if (bad || (zero_none && act_q == pht_pkg::ActFree)) begin
      code = pht_pkg::ResBadId;
    end else if (found) begin
      res_slot = rslot_q;
      res_id   = ent_q.ident;
      res_par  = ent_q.parent;
      if (fire) begin
        if (act_q == pht_pkg::ActFree) begin
          slot_we = 1'b1;
          if (cnt_q < SlotsCnt) begin
            stk_we = 1'b1;
            cnt_d  = cnt_q + 1'b1;
          end
          if (cur_q == ent_q.ident) begin
            cur_d = '0;
          end
        end else if (act_q == pht_pkg::ActCurrent) begin
          cur_d = ent_q.ident;
        end
      end
    end

    if (state_q == pht_pkg::StClear) begin
      slot_we = 1'b1;
      slot_wa = clr_q;
      slot_wd = '{busy: 1'b0, ident: '0, parent: '0};
      stk_we  = 1'b1;
      stk_wa  = clr_q;
      stk_wd  = LastSlot - clr_q;
    end
  end

  assign slot_ext = IdW'(res_slot);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    case (state_q)
      pht_pkg::StClear: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == LastSlot) begin
          state_d = pht_pkg::StIdle;
        end
      end
      pht_pkg::StIdle: begin
        if (accept) begin
          state_d = pht_pkg::StExec;
        end
      end
      pht_pkg::StExec: begin
        if (fire) begin
          state_d   = pht_pkg::StIdle;
          m_valid_d = 1'b1;
          m_data_d  = {4'b0, res_par, res_id, slot_ext[pht_pkg::OutSlotW-1:0], code};
        end
      end
      default: begin
        state_d = pht_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pht_pkg::StClear;
      clr_q     <= '0;
      cnt_q     <= SlotsCnt;
      ctr_q     <= '0;
      cur_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      cnt_q     <= cnt_d;
      ctr_q     <= ctr_d;
      cur_q     <= cur_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    if (accept) begin
      act_q   <= pht_pkg::action_e'(s_axis_tuser[pht_pkg::ActW-1:0]);
      tgt_q   <= in_tgt;
      par_q   <= s_axis_tdata[2*IdW-1:IdW];
      perm_q  <= s_axis_tdata[2*IdW];
      rslot_q <= rd_slot;
    end
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (accept) begin
      ent_q <= slot_mem[rd_slot];
    end
  end

  // free stack memory
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (accept) begin
      stk_q <= stk_mem[stk_raddr];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ----- design/pht_checker.sv -----
`timescale 1ns / 1ps
// pht_checker: port-level checks for process_handle_table_top, bound to it below.
// Uses pht_pkg for result codes and field widths.
module pht_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [pht_pkg::OutTdataW-1:0] m_axis_tdata
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one request in flight: no accept in the cycle after an accept
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in flight");

  // an error result carries no slot, id or parent
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] != pht_pkg::ResOk) |->
      (m_axis_tdata[75:2] == '0))
    else $error("error result with nonzero payload");

  a_code_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] == pht_pkg::ResOk) ||
      (m_axis_tdata[1:0] == pht_pkg::ResNoFree) ||
      (m_axis_tdata[1:0] == pht_pkg::ResBadId))
    else $error("undefined result code");

endmodule

bind process_handle_table_top pht_checker u_pht_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
